/* rtl/mcpwm_pkg.sv */
// Shared types and constants for the multi-channel PWM scheduler.
package mcpwm_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIME_BITS_DEF    = 32;

    localparam int ELAPSED_W  = 16;
    localparam int LEN_W      = 16;
    localparam int CHAN_W     = 3;
    localparam int LEVELS_W   = 8;
    localparam int OUT_TIME_W = 32;
    localparam int MAXP_W     = 16;

    localparam logic [MAXP_W-1:0] MAXP_RESET = 16'hFFFF;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // word address of the register
    localparam logic REG_MAX_PERIOD = 1'b0;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_CFG  = 1'b1
    } cmd_t;

    // per-channel step issued to the channel unit
    typedef struct packed {
        logic vld;
        logic tick;
        logic en;
        logic level;
    } step_t;

    // write-back from the channel unit
    typedef struct packed {
        logic wr;
        logic level;
    } upd_t;

endpackage

/* rtl/mcpwm_ram.sv */
// Generic single write port, single read port RAM with registered read.
module mcpwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mcpwm_chan_unit.sv */
// Shared per-channel unit: due check and toggle, distance key, running minimum.
module mcpwm_chan_unit #(
    parameter int TIME_BITS = mcpwm_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear,
    input  logic [mcpwm_pkg::MAXP_W-1:0]    max_period,
    input  logic [TIME_BITS-1:0]            now,
    input  mcpwm_pkg::step_t                step,
    input  logic [TIME_BITS-1:0]            due,
    input  logic [mcpwm_pkg::LEN_W-1:0]     high_len,
    input  logic [mcpwm_pkg::LEN_W-1:0]     low_len,
    output mcpwm_pkg::upd_t                 upd,
    output logic [TIME_BITS-1:0]            new_due,
    output logic [TIME_BITS-1:0]            best,
    output logic                            busy
);

    localparam logic [TIME_BITS-1:0] HALF = {1'b1, {(TIME_BITS-1){1'b0}}};

    logic [TIME_BITS-1:0] diff;
    logic                 is_due;
    logic                 act;
    logic [TIME_BITS-1:0] due_lo;
    logic [TIME_BITS-1:0] due_hi;

    logic                 b_vld_reg;
    logic                 b_en_reg;
    logic [TIME_BITS-1:0] b_due_reg;
    logic                 c_vld_reg;
    logic                 c_en_reg;
    logic [TIME_BITS-1:0] c_key_reg;
    logic [TIME_BITS-1:0] best_reg;
    logic [TIME_BITS-1:0] best_next;

    // stage A: due test and both candidate due times side by side
    always_comb
    begin
        diff   = now - due;
        is_due = ~diff[TIME_BITS-1];
        act    = step.vld && step.tick && step.en && is_due;
        due_lo = due + TIME_BITS'(low_len);
        due_hi = due + TIME_BITS'(high_len);
        upd.wr    = 1'b0;
        upd.level = step.level;
        new_due   = due;
        if (act)
        begin
            if (step.level && (low_len != '0))
            begin
                upd.wr    = 1'b1;
                upd.level = 1'b0;
                new_due   = due_lo;
            end
            else if (high_len != '0)
            begin
                upd.wr    = 1'b1;
                upd.level = 1'b1;
                new_due   = due_hi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= step.vld;
            c_vld_reg <= b_vld_reg;
        end
    end

    // stages B and C: signed distance key, then the minimum
    always_comb
    begin
        best_next = best_reg;
        if (clear)
        begin
            best_next = TIME_BITS'(max_period) ^ HALF;
        end
        else if (c_vld_reg && c_en_reg)
        begin
            if (c_key_reg < best_reg)
            begin
                best_next = c_key_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_en_reg  <= step.en;
        b_due_reg <= new_due;
        c_en_reg  <= b_en_reg;
        c_key_reg <= (b_due_reg - now) ^ HALF;
        best_reg  <= best_next;
    end

    assign best = best_reg;
    assign busy = b_vld_reg | c_vld_reg;

endmodule

/* rtl/multi_channel_pwm_scheduler_unit.sv */
// Top level of the multi-channel PWM scheduler.
//
// Each input transaction is a tick (tuser = 0), which adds elapsed timer clocks to the
// wrapping time count and toggles every enabled channel that has come due, or a
// configure (tuser = 1), which loads one channel's high and low lengths and enable and
// restarts its phase at the current time. Every input transaction gives exactly one
// output transaction with the channel levels, the time count and the earliest due time
// of the enabled channels, capped at now plus max_period. Channel due times and lengths
// sit in a small RAM; one shared channel unit walks the channels one per cycle. After the
// walk the channel pipeline drains, the sequencer sees it empty and moves to its finish
// state, and that state loads the output register. The input side is not ready while
// an item is in work and takes the next item at the earliest in the cycle the result
// appears; the result waits in an output register, and the next item can be taken while
// it waits. max_period is written over the APB-style port at byte address 0.
module multi_channel_pwm_scheduler_unit #(
    parameter int NUM_CHANNELS = mcpwm_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = mcpwm_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // elapsed[15:0], channel[18:16], high_time[34:19], low_time[50:35], enable[51]
    input  logic [mcpwm_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // levels[7:0], now[39:8], next_event[71:40]
    output logic [mcpwm_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcpwm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mcpwm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mcpwm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W   = $clog2(NUM_CHANNELS + 1);
    localparam int LEN_W   = mcpwm_pkg::LEN_W;
    localparam int ENTRY_W = TIME_BITS + 2 * LEN_W;
    localparam int LVL_EXT = (NUM_CHANNELS > mcpwm_pkg::LEVELS_W) ? NUM_CHANNELS
                                                                  : mcpwm_pkg::LEVELS_W;
    localparam int TIME_EXT = (TIME_BITS > mcpwm_pkg::OUT_TIME_W) ? TIME_BITS
                                                                  : mcpwm_pkg::OUT_TIME_W;
    localparam logic [TIME_BITS-1:0] HALF = {1'b1, {(TIME_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic [mcpwm_pkg::ELAPSED_W-1:0] in_elapsed;
    logic [mcpwm_pkg::CHAN_W-1:0]    in_channel;
    logic [LEN_W-1:0]                in_high;
    logic [LEN_W-1:0]                in_low;
    logic                            in_enable;
    logic                            s_accept;
    logic                            tick_accept;
    logic                            cfg_accept;
    logic                            cfg_in_range;
    logic [CH_W-1:0]                 cfg_idx;

    assign in_elapsed = s_tdata[15:0];
    assign in_channel = s_tdata[18:16];
    assign in_high    = s_tdata[34:19];
    assign in_low     = s_tdata[50:35];
    assign in_enable  = s_tdata[51];

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign tick_accept  = s_accept && (s_tuser == mcpwm_pkg::CMD_TICK);
    assign cfg_accept   = s_accept && (s_tuser == mcpwm_pkg::CMD_CFG);
    assign cfg_in_range = 32'(in_channel) < 32'(NUM_CHANNELS);
    assign cfg_idx      = CH_W'(in_channel);

    // configuration register
    logic [mcpwm_pkg::MAXP_W-1:0] max_period_reg;
    logic                         reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == mcpwm_pkg::REG_MAX_PERIOD);
    assign prdata = (paddr[2] == mcpwm_pkg::REG_MAX_PERIOD)
                    ? mcpwm_pkg::APB_DATA_W'(max_period_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_period_reg <= mcpwm_pkg::MAXP_RESET;
        end
        else if (reg_wr)
        begin
            max_period_reg <= pwdata[mcpwm_pkg::MAXP_W-1:0];
        end
    end

    // channel state: flags in flops, due time and lengths in RAM
    logic [TIME_BITS-1:0]    now_reg;
    logic [NUM_CHANNELS-1:0] en_reg;
    logic [NUM_CHANNELS-1:0] level_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    a_vld_reg;
    logic                    tick_mode_reg;
    logic [CH_W-1:0]         a_idx_reg;

    logic                    issue;
    logic                    ram_we;
    logic [CH_W-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    mcpwm_pkg::step_t        step;
    mcpwm_pkg::upd_t         upd;
    logic [TIME_BITS-1:0]    new_due;
    logic [TIME_BITS-1:0]    best;
    logic                    busy;

    assign issue = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(NUM_CHANNELS));

    // RAM entry: low length, high length, due time (lowest)
    always_comb
    begin
        if (cfg_accept)
        begin
            ram_we    = cfg_in_range;
            ram_waddr = cfg_idx;
            ram_wdata = {in_low, in_high, now_reg};
        end
        else
        begin
            ram_we    = upd.wr;
            ram_waddr = a_idx_reg;
            ram_wdata = {ram_rdata[ENTRY_W-1:TIME_BITS], new_due};
        end
    end

    mcpwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[CH_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        step.vld   = a_vld_reg;
        step.tick  = tick_mode_reg;
        step.en    = en_reg[a_idx_reg];
        step.level = level_reg[a_idx_reg];
    end

    mcpwm_chan_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_chan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (s_accept),
        .max_period (max_period_reg),
        .now        (now_reg),
        .step       (step),
        .due        (ram_rdata[TIME_BITS-1:0]),
        .high_len   (ram_rdata[TIME_BITS+LEN_W-1:TIME_BITS]),
        .low_len    (ram_rdata[ENTRY_W-1:TIME_BITS+LEN_W]),
        .upd        (upd),
        .new_due    (new_due),
        .best       (best),
        .busy       (busy)
    );

    // sequencer
    logic load_out;

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // walk finished and channel pipeline drained
                if (!issue && !a_vld_reg && !busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            en_reg        <= '0;
            level_reg     <= '0;
            cnt_reg       <= '0;
            a_vld_reg     <= 1'b0;
            tick_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_vld_reg <= issue;
            if (s_accept)
            begin
                cnt_reg       <= '0;
                tick_mode_reg <= tick_accept;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (tick_accept)
            begin
                now_reg <= now_reg + TIME_BITS'(in_elapsed);
            end
            if (cfg_accept && cfg_in_range)
            begin
                en_reg[cfg_idx] <= in_enable;
            end
            if (upd.wr)
            begin
                level_reg[a_idx_reg] <= upd.level;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= cnt_reg[CH_W-1:0];
    end

    // output register
    logic                            m_tvalid_reg;
    logic [mcpwm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [TIME_BITS-1:0]            next_event;
    logic [TIME_EXT-1:0]             now_ext;
    logic [TIME_EXT-1:0]             next_ext;
    logic [LVL_EXT-1:0]              lvl_ext;

    assign next_event = now_reg + (best ^ HALF);
    assign now_ext    = TIME_EXT'(now_reg);
    assign next_ext   = TIME_EXT'(next_event);
    assign lvl_ext    = LVL_EXT'(level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= {next_ext[mcpwm_pkg::OUT_TIME_W-1:0],
                            now_ext[mcpwm_pkg::OUT_TIME_W-1:0],
                            lvl_ext[mcpwm_pkg::LEVELS_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick_accept |=> (now_reg == $past(now_reg)))
        else $error("time count moved without a tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        upd.wr |-> (en_reg[a_idx_reg] && tick_mode_reg && (state_reg == ST_SCAN)))
        else $error("channel toggled outside a tick pass or while disabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_accept && cfg_in_range) |=> (en_reg[$past(cfg_idx)] == $past(in_enable)))
        else $error("configure did not load the channel enable");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the multi-channel PWM scheduler: stream and APB stimulus.
`timescale 1ns / 1ps

module testbench;

    localparam int NCH           = mcpwm_pkg::NUM_CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 20;      // comfortably above the item latency
    localparam int LONG_HOLD     = 300;     // receiver hold-off for the back-pressure test
    localparam int PHASE_ITEMS   = 290;
    localparam int NUM_PHASES    = 5;
    localparam int SOAK_TICKS    = 96;      // full-size ticks sent back to back

    // byte address of the only register
    localparam logic [mcpwm_pkg::APB_ADDR_W-1:0] MAXP_ADDR = {mcpwm_pkg::REG_MAX_PERIOD,
                                                              2'b00};

    // one result transaction, unpacked
    typedef struct packed {
        logic [7:0]  levels;
        logic [31:0] now;
        logic [31:0] next_event;
    } pwm_frame_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [mcpwm_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [mcpwm_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [mcpwm_pkg::APB_ADDR_W-1:0] paddr;
    logic [mcpwm_pkg::APB_DATA_W-1:0] pwdata;
    logic [mcpwm_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    multi_channel_pwm_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Scheduler model state, kept in step with accepted transactions
    // ------------------------------------------------------------------
    logic [31:0] pwm_now;
    logic [31:0] ch_due  [NCH];
    logic [15:0] ch_high [NCH];
    logic [15:0] ch_low  [NCH];
    logic        ch_en   [NCH];
    logic        ch_lvl  [NCH];
    logic [15:0] cap_reg;               // max_period as last written

    pwm_frame_t  pwm_frames_due [$];    // results still owed by the block
    int          mismatch_count;

    // stimulus control shared between the test tasks and the two drivers
    bit          steady_source;         // no gaps from the sender
    bit          steady_sink;           // receiver always ready
    bit          hold_results;          // request for one long receiver hold-off
    int          burst_left;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one item to the model and returns the result it gives.
    // A tick advances time then toggles each enabled, due channel once; a
    // configure loads one channel and restarts its phase at the current time.
    // ------------------------------------------------------------------
    function automatic pwm_frame_t step_pwm_model(input mcpwm_pkg::cmd_t cmd,
                                                  input logic [15:0] elapsed,
                                                  input logic [2:0] chan,
                                                  input logic [15:0] hi, input logic [15:0] lo,
                                                  input logic en);
        pwm_frame_t        f;
        logic [31:0]       lag;
        logic signed [31:0] ahead;
        logic signed [31:0] best;
        if (cmd == mcpwm_pkg::CMD_TICK)
        begin
            pwm_now = pwm_now + 32'(elapsed);
            for (int c = 0; c < NCH; c++)
            begin
                lag = pwm_now - ch_due[c];
                // due when the wrapped distance since the due time is not negative
                if (ch_en[c] && !lag[31])
                begin
                    if (ch_lvl[c] && ch_low[c] != 16'd0)
                    begin
                        ch_lvl[c] = 1'b0;
                        ch_due[c] = ch_due[c] + 32'(ch_low[c]);
                    end
                    else if (ch_high[c] != 16'd0)
                    begin
                        ch_lvl[c] = 1'b1;
                        ch_due[c] = ch_due[c] + 32'(ch_high[c]);
                    end
                    // both lengths zero: level and due time stay put
                end
            end
        end
        else
        begin
            ch_high[chan] = hi;
            ch_low[chan]  = lo;
            ch_en[chan]   = en;
            ch_due[chan]  = pwm_now;
        end
        // earliest enabled due time by signed distance, capped at now + max_period
        best = $signed({16'd0, cap_reg});
        for (int c = 0; c < NCH; c++)
        begin
            f.levels[c] = ch_lvl[c];
            ahead = $signed(ch_due[c] - pwm_now);
            if (ch_en[c] && ahead < best)
                best = ahead;
        end
        f.now        = pwm_now;
        f.next_event = pwm_now + 32'(best);
        return f;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Scoreboard. Outputs are checked before the new expectation is queued, so
    // a result can never be matched against the item accepted on the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        pwm_frame_t got;
        pwm_frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.levels     = m_tdata[7:0];
            got.now        = m_tdata[39:8];
            got.next_event = m_tdata[71:40];
            if (pwm_frames_due.size() == 0)
                report_mismatch("result with nothing outstanding", got.now, 32'd0);
            else
            begin
                want = pwm_frames_due.pop_front();
                if (got.levels !== want.levels)
                    report_mismatch("levels", 32'(got.levels), 32'(want.levels));
                if (got.now !== want.now)
                    report_mismatch("now", got.now, want.now);
                if (got.next_event !== want.next_event)
                    report_mismatch("next_event", got.next_event, want.next_event);
            end
        end
        if (rst_n && s_tvalid && s_tready)
            pwm_frames_due.push_back(step_pwm_model(mcpwm_pkg::cmd_t'(s_tuser),
                                                    s_tdata[15:0], s_tdata[18:16],
                                                    s_tdata[34:19], s_tdata[50:35],
                                                    s_tdata[51]));
    end

    // ------------------------------------------------------------------
    // Result receiver: its own stall pattern, switching mode every so often,
    // plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int mode;
        int span;
        m_tready = 1'b0;
        mode     = 0;
        span     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_results = 1'b0;
            end
            else if (steady_sink)
                m_tready = 1'b1;
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 160);
                end
                span--;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = $urandom_range(0, 1);
                    2:       m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = (span % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transaction. The sender works in bursts; between bursts tvalid
    // may drop for a random gap. Returns at the edge where the item is taken, with
    // tvalid still high: the next call or drain() decides what follows.
    task automatic send_item(input mcpwm_pkg::cmd_t cmd, input logic [15:0] el,
                             input logic [2:0] ch, input logic [15:0] hi,
                             input logic [15:0] lo, input logic en);
        int gap;
        if (!steady_source)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {4'b0, en, lo, hi, ch, el};
        do @(posedge clk); while (!s_tready);
    endtask

    // ignored fields carry random junk
    task automatic send_tick(input logic [15:0] el);
        send_item(mcpwm_pkg::CMD_TICK, el, 3'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
    endtask

    task automatic send_cfg(input logic [2:0] ch, input logic [15:0] hi, input logic [15:0] lo,
                            input logic en);
        send_item(mcpwm_pkg::CMD_CFG, 16'($urandom), ch, hi, lo, en);
    endtask

    // period lengths: mostly short, with zero and the extremes now and then
    function automatic logic [15:0] rand_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'd0;
        else if (pick < 70)
            return 16'($urandom_range(1, 30));
        else if (pick < 90)
            return 16'($urandom_range(0, 2000));
        else if (pick < 98)
            return 16'($urandom);
        return 16'hFFFF;
    endfunction

    function automatic logic [15:0] rand_elapsed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 16'($urandom_range(0, 40));
        else if (pick < 85)
            return 16'($urandom_range(0, 1000));
        else if (pick < 95)
            return 16'($urandom);
        return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
    endfunction

    task automatic send_random_item();
        mcpwm_pkg::cmd_t cmd;
        cmd = ($urandom_range(0, 99) < 70) ? mcpwm_pkg::CMD_TICK : mcpwm_pkg::CMD_CFG;
        send_item(cmd, rand_elapsed(), 3'($urandom_range(0, NCH - 1)), rand_len(), rand_len(),
                  ($urandom_range(0, 7) != 0));
    endtask

    // Sender pauses until every result is back, then lets the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pwm_frames_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = MAXP_ADDR;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr)
            cap_reg = wdata[15:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_cap_readback();
        logic [31:0] rd;
        apb_access(1'b0, $urandom, rd);
        if (rd !== {16'd0, cap_reg})
            report_mismatch("max_period readback", rd, {16'd0, cap_reg});
    endtask

    // register writes only ever happen with the block idle
    task automatic set_cap(input logic [31:0] wval);
        logic [31:0] unused_rd;
        drain();
        apb_access(1'b1, wval, unused_rd);
        check_cap_readback();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset value, then writes with and without junk in the unused upper bits
    task automatic test_register_port();
        check_cap_readback();
        set_cap($urandom);
        set_cap(32'hFFFF_0000);
        set_cap(32'h0000_FFFF);
    endtask

    // hand-picked sequences around the corner cases of the channel walk
    task automatic test_directed();
        send_tick(16'd0);                            // all idle: next event is the cap
        send_cfg(3'd0, 16'd3, 16'd5, 1'b1);          // phase restarts at now
        send_tick(16'd0);                            // due at once: goes high
        send_tick(16'd2);                            // not yet due
        send_tick(16'd1);                            // exactly due: goes low
        send_tick(16'd20);                           // overdue: one change only
        send_tick(16'd0);                            // still overdue: catches up
        send_cfg(3'd1, 16'd0, 16'd7, 1'b1);          // zero high time: never high
        send_cfg(3'd2, 16'd4, 16'd0, 1'b1);          // zero low time: stays high
        send_cfg(3'd3, 16'd0, 16'd0, 1'b1);          // both zero: due time is frozen
        send_cfg(3'd7, 16'hFFFF, 16'hFFFF, 1'b1);    // longest periods, top channel
        send_tick(16'hFFFF);
        send_tick(16'd1);
        send_cfg(3'd4, 16'd5, 16'd5, 1'b0);          // configured but disabled
        send_tick(16'd10);
        send_cfg(3'd0, 16'd2, 16'd2, 1'b0);          // disable mid-phase: level held
        send_tick(16'd6);
        send_cfg(3'd2, 16'd9, 16'd3, 1'b1);          // reconfigure while high
        send_tick(16'd3);
        send_tick(16'h8000);
        send_cfg(3'd5, 16'd1, 16'd1, 1'b1);
        send_tick(16'd1);
        send_tick(16'd1);
        drain();
    endtask

    // random traffic under several cap settings, including both extremes
    task automatic test_random_phases();
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       set_cap(32'hFFFF_FFFF);
                1:       set_cap($urandom & 32'hFFFF_0000);      // cap of zero
                2:       set_cap(32'($urandom_range(1, 40)));
                3:       set_cap($urandom);
                default: set_cap(32'h0000_FFFF);
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls;
    // afterwards the sender waits for every outstanding result
    task automatic test_backpressure();
        hold_results  = 1'b1;
        steady_source = 1'b1;
        repeat (16) send_random_item();
        steady_source = 1'b0;
        drain();
        repeat (8) send_random_item();
        drain();
    endtask

    // full-rate soak of maximum-size ticks with a reconfigure now and then
    task automatic test_full_rate();
        set_cap(32'($urandom_range(0, 65535)));
        steady_source = 1'b1;
        steady_sink   = 1'b1;
        for (int c = 0; c < NCH; c++)
            send_cfg(3'(c), rand_len(), rand_len(), 1'b1);
        for (int i = 0; i < SOAK_TICKS; i++)
        begin
            send_tick(16'hFFFF);
            if (i % 32 == 31)
                send_cfg(3'($urandom_range(0, NCH - 1)), rand_len(), rand_len(),
                         ($urandom_range(0, 3) != 0));
        end
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        repeat (64) send_random_item();
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        pwm_now        = '0;
        cap_reg        = mcpwm_pkg::MAXP_RESET;
        mismatch_count = 0;
        steady_source  = 1'b0;
        steady_sink    = 1'b0;
        hold_results   = 1'b0;
        burst_left     = 0;
        for (int c = 0; c < NCH; c++)
        begin
            ch_due[c]  = '0;
            ch_high[c] = '0;
            ch_low[c]  = '0;
            ch_en[c]   = 1'b0;
            ch_lvl[c]  = 1'b0;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();        // under the reset value of max_period
        test_register_port();
        test_random_phases();
        test_backpressure();
        test_full_rate();

        drain();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
